### src/tpc_pkg.sv
// Shared types, constants and helpers for the temperature/pressure compensation core.
package tpc_pkg;

	localparam logic [31:0] OFS_FINE  = 32'd64000;
	localparam logic [31:0] OFS_PRESS = 32'd1048576;
	localparam logic [31:0] SCALE_P   = 32'd3125;
	localparam logic [31:0] OFS_P1    = 32'd32768;
	localparam logic [31:0] RND_TEMP  = 32'd128;
	localparam int          DIV_BITS  = 32;

	localparam logic [2:0] REG_TEMP_CAL   = 3'd0;
	localparam logic [2:0] REG_PRESS_LOW  = 3'd1;
	localparam logic [2:0] REG_PRESS_HIGH = 3'd2;
	localparam logic [2:0] REG_PRESS_LAST = 3'd3;

	typedef struct packed {
		logic [15:0] t1, t2, t3;
		logic [15:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
	} cal_t;

	// Words that ride alongside the divider.
	typedef struct packed {
		logic [31:0] temp;
		logic        zero;
		logic        sel;
	} side_t;

	typedef struct packed {
		logic [31:0] den;
		logic [31:0] num;
		side_t       side;
	} front_t;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage

### src/temp_pressure_compensation_core.sv
// Top level of the temperature/pressure compensation core.
// Usage: write the four calibration registers through wr_en/wr_index/wr_data
// while the core is idle (index 0 temperature, 1 and 2 pressure words P1..P8,
// 3 the word P9). Each input word is a raw temperature and raw pressure pair,
// taken when in_valid is high and in_stall low. Each input word produces one
// output word (temperature in 0.01 degC, pressure in Pa, divisor-zero flag),
// taken when out_valid is high and out_stall low.
// The pipeline has 10 front stages, 32 divider stages (one quotient bit
// each) and 3 back stages. One word can enter per cycle unless stalled.
// When the receiver stalls a valid output word, the whole pipeline holds and
// in_stall is raised in the same cycle; nothing is lost or repeated.
// Reset clears all pipeline valid bits and the calibration registers.
module temp_pressure_compensation_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [19:0] raw_temperature,
	input  logic [19:0] raw_pressure,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [31:0] temperature_centi,
	output logic [31:0] pressure_pa,
	output logic        divisor_zero,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [63:0] wr_data
);
	import tpc_pkg::*;

	logic [47:0] tcal_q;
	logic [63:0] plow_q, phigh_q;
	logic [15:0] plast_q;
	cal_t        cal;
	logic        adv;
	logic        fv, dv;
	front_t      fdata;
	logic [31:0] quo, temp_u;
	side_t       dside;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcal_q  <= '0;
			plow_q  <= '0;
			phigh_q <= '0;
			plast_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_TEMP_CAL:   tcal_q  <= wr_data[47:0];
				REG_PRESS_LOW:  plow_q  <= wr_data;
				REG_PRESS_HIGH: phigh_q <= wr_data;
				REG_PRESS_LAST: plast_q <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cal.t1 = tcal_q[15:0];
		cal.t2 = tcal_q[31:16];
		cal.t3 = tcal_q[47:32];
		cal.p1 = plow_q[15:0];
		cal.p2 = plow_q[31:16];
		cal.p3 = plow_q[47:32];
		cal.p4 = plow_q[63:48];
		cal.p5 = phigh_q[15:0];
		cal.p6 = phigh_q[31:16];
		cal.p7 = phigh_q[47:32];
		cal.p8 = phigh_q[63:48];
		cal.p9 = plast_q;
	end

	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	tpc_front u_front (
		.clk, .arst_n, .adv,
		.in_valid(in_valid),
		.raw_temperature, .raw_pressure,
		.cal,
		.out_valid(fv),
		.out_data(fdata)
	);

	tpc_div u_div (
		.clk, .arst_n, .adv,
		.in_valid(fv),
		.in_data(fdata),
		.out_valid(dv),
		.quo,
		.out_side(dside)
	);

	tpc_back u_back (
		.clk, .arst_n, .adv,
		.in_valid(dv),
		.quo,
		.side(dside),
		.cal,
		.out_valid,
		.temperature_centi(temp_u),
		.pressure_pa,
		.divisor_zero
	);

	assign temperature_centi = $signed(temp_u);

	a_zero_press: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divisor_zero |-> pressure_pa == '0)
		else $error("pressure not forced to zero on zero divisor");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled output word");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$past(out_valid && out_stall) |-> $stable(pressure_pa) && $stable(out_valid))
		else $error("pipeline moved while stalled");

endmodule

### src/tpc_front.sv
// Fine temperature, temperature and pressure divisor/dividend pipeline.
module tpc_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          in_valid,
	input  logic [19:0]   raw_temperature,
	input  logic [19:0]   raw_pressure,
	input  tpc_pkg::cal_t cal,
	output logic          out_valid,
	output tpc_pkg::front_t out_data
);
	import tpc_pkg::*;

	logic [9:0]  v_q;
	logic [31:0] x1_s1, d_s1, m1_s2, dd_s2, a_s3, e_s3, fine_s4;
	logic [31:0] temp_s5, pa_s5;
	logic [31:0] qq_s6, ap5_s6, p2a_s6, b1_s7, p3m_s7, ap5_s7, p2a_s7;
	logic [31:0] b_s8, a2_s8, am_s9, pn_s9, den_s10, pm_s10;
	logic [19:0] ap_s1, ap_s2, ap_s3, ap_s4, ap_s5, ap_s6, ap_s7, ap_s8;
	logic [31:0] temp_s6, temp_s7, temp_s8, temp_s9, temp_s10;
	logic [31:0] at_ext, f5, q5;

	assign at_ext = {12'd0, raw_temperature};
	assign f5 = (fine_s4 << 2) + fine_s4 + RND_TEMP;
	// The quarter term is taken after the fine offset has been removed.
	assign q5 = $unsigned($signed(pa_s5) >>> 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[8:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x1_s1 <= (at_ext >> 3) - ({16'd0, cal.t1} << 1);
			d_s1  <= (at_ext >> 4) - {16'd0, cal.t1};
			ap_s1 <= raw_pressure;

			m1_s2 <= x1_s1 * sx16(cal.t2);
			dd_s2 <= d_s1 * d_s1;
			ap_s2 <= ap_s1;

			a_s3  <= $unsigned($signed(m1_s2) >>> 11);
			e_s3  <= $unsigned($signed(dd_s2) >>> 12) * sx16(cal.t3);
			ap_s3 <= ap_s2;

			fine_s4 <= a_s3 + $unsigned($signed(e_s3) >>> 14);
			ap_s4   <= ap_s3;

			temp_s5 <= $unsigned($signed(f5) >>> 8);
			pa_s5   <= $unsigned($signed(fine_s4) >>> 1) - OFS_FINE;
			ap_s5   <= ap_s4;

			qq_s6   <= q5 * q5;
			ap5_s6  <= pa_s5 * sx16(cal.p5);
			p2a_s6  <= pa_s5 * sx16(cal.p2);
			temp_s6 <= temp_s5;
			ap_s6   <= ap_s5;

			b1_s7   <= $unsigned($signed(qq_s6) >>> 11) * sx16(cal.p6);
			p3m_s7  <= sx16(cal.p3) * $unsigned($signed(qq_s6) >>> 13);
			ap5_s7  <= ap5_s6;
			p2a_s7  <= p2a_s6;
			temp_s7 <= temp_s6;
			ap_s7   <= ap_s6;

			b_s8    <= $unsigned($signed(b1_s7 + (ap5_s7 << 1)) >>> 2)
				+ (sx16(cal.p4) << 16);
			a2_s8   <= $unsigned($signed($unsigned($signed(p3m_s7) >>> 3)
				+ $unsigned($signed(p2a_s7) >>> 1)) >>> 18);
			temp_s8 <= temp_s7;
			ap_s8   <= ap_s7;

			am_s9   <= (OFS_P1 + a2_s8) * {16'd0, cal.p1};
			pn_s9   <= (OFS_PRESS - {12'd0, ap_s8}) - $unsigned($signed(b_s8) >>> 12);
			temp_s9 <= temp_s8;

			den_s10  <= $unsigned($signed(am_s9) >>> 15);
			pm_s10   <= pn_s9 * SCALE_P;
			temp_s10 <= temp_s9;
		end
	end

	// The divisor is unsigned; a dividend below 2^31 is doubled before dividing.
	always_comb begin
		out_data.den       = den_s10;
		out_data.num       = pm_s10[31] ? pm_s10 : (pm_s10 << 1);
		out_data.side.temp = temp_s10;
		out_data.side.zero = (den_s10 == '0);
		out_data.side.sel  = pm_s10[31];
	end
	assign out_valid = v_q[9];

endmodule

### src/tpc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module tpc_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_valid,
	input  tpc_pkg::front_t in_data,
	output logic            out_valid,
	output logic [31:0]     quo,
	output tpc_pkg::side_t  out_side
);
	import tpc_pkg::*;

	logic [DIV_BITS:1] v_q;
	logic [31:0] rem_q [1:DIV_BITS];
	logic [31:0] num_q [1:DIV_BITS];
	logic [31:0] den_q [1:DIV_BITS];
	logic [31:0] quo_q [1:DIV_BITS];
	side_t       side_q [1:DIV_BITS];

	for (genvar k = 0; k < DIV_BITS; k++) begin : g_stage
		logic [31:0] rem_i, num_i, den_i, quo_i;
		side_t       side_i;
		logic        v_i;
		logic [32:0] trial, diff;
		logic        ge;

		if (k == 0) begin : g_head
			assign rem_i  = '0;
			assign num_i  = in_data.num;
			assign den_i  = in_data.den;
			assign quo_i  = '0;
			assign side_i = in_data.side;
			assign v_i    = in_valid;
		end else begin : g_tail
			assign rem_i  = rem_q[k];
			assign num_i  = num_q[k];
			assign den_i  = den_q[k];
			assign quo_i  = quo_q[k];
			assign side_i = side_q[k];
			assign v_i    = v_q[k];
		end

		assign trial = {rem_i, num_i[31]};
		assign diff  = trial - {1'b0, den_i};
		assign ge    = (trial >= {1'b0, den_i});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k+1] <= 1'b0;
			end else if (adv) begin
				v_q[k+1] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_q[k+1]  <= ge ? diff[31:0] : trial[31:0];
				num_q[k+1]  <= num_i << 1;
				den_q[k+1]  <= den_i;
				quo_q[k+1]  <= {quo_i[30:0], ge};
				side_q[k+1] <= side_i;
			end
		end
	end

	assign out_valid = v_q[DIV_BITS];
	assign quo       = side_q[DIV_BITS].sel ? (quo_q[DIV_BITS] << 1) : quo_q[DIV_BITS];
	assign out_side  = side_q[DIV_BITS];

endmodule

### src/tpc_back.sv
// Final pressure correction with P7..P9 and the output register.
module tpc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           in_valid,
	input  logic [31:0]    quo,
	input  tpc_pkg::side_t side,
	input  tpc_pkg::cal_t  cal,
	output logic           out_valid,
	output logic [31:0]    temperature_centi,
	output logic [31:0]    pressure_pa,
	output logic           divisor_zero
);
	import tpc_pkg::*;

	logic [1:0]  v_q;
	logic        v_s3;
	logic [31:0] ss_s1, m8_s1, q_s1, a3_s2, b3_s2, q_s2, t_s1, t_s2;
	logic        z_s1, z_s2;
	logic [31:0] sh3, corr;

	assign sh3  = quo >> 3;
	assign corr = $unsigned($signed(a3_s2) >>> 12) + b3_s2 + sx16(cal.p7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q  <= '0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_q  <= {v_q[0], in_valid};
			v_s3 <= v_q[1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ss_s1 <= sh3 * sh3;
			m8_s1 <= (quo >> 2) * sx16(cal.p8);
			q_s1  <= quo;
			t_s1  <= side.temp;
			z_s1  <= side.zero;

			a3_s2 <= sx16(cal.p9) * (ss_s1 >> 13);
			b3_s2 <= $unsigned($signed(m8_s1) >>> 13);
			q_s2  <= q_s1;
			t_s2  <= t_s1;
			z_s2  <= z_s1;

			temperature_centi <= t_s2;
			pressure_pa       <= z_s2 ? '0 : q_s2 + $unsigned($signed(corr) >>> 4);
			divisor_zero      <= z_s2;
		end
	end

	assign out_valid = v_s3;

endmodule

### dv/tb_top.sv
// Self-checking testbench for the temperature and pressure compensation core.
`timescale 1ns / 100ps

module tb_top;
	import tpc_pkg::*;

	// Holds the calibration, computes compensated words and checks the core's output.
	class comp_scoreboard;
		logic [47:0] tcal;
		logic [63:0] plow, phigh;
		logic [15:0] plast;
		logic [31:0] want_temp[$];
		logic [31:0] want_press[$];
		logic        want_zero[$];
		int errors;
		int checked;
		int zero_seen;

		function new();
			tcal = '0;
			plow = '0;
			phigh = '0;
			plast = '0;
			errors = 0;
			checked = 0;
			zero_seen = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [63:0] val);
			case (idx)
				REG_TEMP_CAL: begin
					tcal = val[47:0];
				end
				REG_PRESS_LOW: begin
					plow = val;
				end
				REG_PRESS_HIGH: begin
					phigh = val;
				end
				REG_PRESS_LAST: begin
					plast = val[15:0];
				end
				default: begin
				end
			endcase
		endfunction

		static function logic [31:0] ext(logic [15:0] v);
			return {{16{v[15]}}, v};
		endfunction

		static function logic [31:0] sar(logic [31:0] x, int n);
			return $unsigned($signed(x) >>> n);
		endfunction

		function void note_sample(logic [19:0] rt, logic [19:0] rp);
			logic [31:0] adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
			logic [31:0] a, b, d, q, fine, temp, p;
			logic zero;
			adc_t = {12'd0, rt};
			adc_p = {12'd0, rp};
			t1 = {16'd0, tcal[15:0]};
			t2 = ext(tcal[31:16]);
			t3 = ext(tcal[47:32]);
			p1 = {16'd0, plow[15:0]};
			p2 = ext(plow[31:16]);
			p3 = ext(plow[47:32]);
			p4 = ext(plow[63:48]);
			p5 = ext(phigh[15:0]);
			p6 = ext(phigh[31:16]);
			p7 = ext(phigh[47:32]);
			p8 = ext(phigh[63:48]);
			p9 = ext(plast);
			zero = 1'b0;
			a = sar(((adc_t >> 3) - (t1 << 1)) * t2, 11);
			d = (adc_t >> 4) - t1;
			b = sar(sar(d * d, 12) * t3, 14);
			fine = a + b;
			temp = sar(fine * 32'd5 + 32'd128, 8);
			a = sar(fine, 1) - 32'd64000;
			q = sar(a, 2);
			b = sar(q * q, 11) * p6;
			b = b + ((a * p5) << 1);
			b = sar(b, 2) + (p4 << 16);
			a = sar(sar(p3 * sar(q * q, 13), 3) + sar(p2 * a, 1), 18);
			a = sar((32'd32768 + a) * p1, 15);
			if (a == 0) begin
				p = '0;
				zero = 1'b1;
			end else begin
				p = ((32'd1048576 - adc_p) - sar(b, 12)) * 32'd3125;
				if (p < 32'h8000_0000)
					p = (p << 1) / a;
				else
					p = (p / a) * 32'd2;
				a = sar(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
				b = sar((p >> 2) * p8, 13);
				p = p + sar(a + b + p7, 4);
			end
			want_temp.push_back(temp);
			want_press.push_back(p);
			want_zero.push_back(zero);
		endfunction

		function void check_word(logic [31:0] t, logic [31:0] p, logic z);
			logic [31:0] et, ep;
			logic ez;
			if (want_temp.size() == 0) begin
				$display("%0t: unexpected output word t=%h p=%h z=%b", $time, t, p, z);
				errors++;
				return;
			end
			et = want_temp.pop_front();
			ep = want_press.pop_front();
			ez = want_zero.pop_front();
			checked++;
			if (ez)
				zero_seen++;
			if (t !== et) begin
				$display("%0t: temperature_centi expected %h actual %h", $time, et, t);
				errors++;
			end
			if (p !== ep) begin
				$display("%0t: pressure_pa expected %h actual %h", $time, ep, p);
				errors++;
			end
			if (z !== ez) begin
				$display("%0t: divisor_zero expected %b actual %b", $time, ez, z);
				errors++;
			end
		endfunction

		function int pending();
			return want_temp.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [19:0] raw_temperature;
	logic [19:0] raw_pressure;
	logic        out_valid;
	logic        out_stall;
	logic signed [31:0] temperature_centi;
	logic [31:0] pressure_pa;
	logic        divisor_zero;
	logic        wr_en;
	logic [2:0]  wr_index;
	logic [63:0] wr_data;

	comp_scoreboard sb;
	int stall_mode;
	int sent;

	temp_pressure_compensation_core u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.raw_temperature  (raw_temperature),
		.raw_pressure     (raw_pressure),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.temperature_centi(temperature_centi),
		.pressure_pa      (pressure_pa),
		.divisor_zero     (divisor_zero),
		.wr_en            (wr_en),
		.wr_index         (wr_index),
		.wr_data          (wr_data)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Accepted words are recorded and checked at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_sample(raw_temperature, raw_pressure);
			if (out_valid && !out_stall)
				sb.check_word(temperature_centi, pressure_pa, divisor_zero);
		end
	end

	// The receiver stalls on a pattern that changes with the phase of the run.
	always @(negedge clk) begin
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 1) == 0);
			default: out_stall <= ($urandom_range(0, 9) != 0);
		endcase
	end

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		sb.set_reg(idx, val);
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic load_cal(input logic [47:0] t, input logic [63:0] lo,
			input logic [63:0] hi, input logic [15:0] last);
		write_reg(REG_TEMP_CAL, {16'd0, t});
		write_reg(REG_PRESS_LOW, lo);
		write_reg(REG_PRESS_HIGH, hi);
		write_reg(REG_PRESS_LAST, {48'd0, last});
	endtask

	// Drives one word and holds it until the core takes it.
	task automatic send_sample(input logic [19:0] rt, input logic [19:0] rp);
		in_valid <= 1'b1;
		raw_temperature <= rt;
		raw_pressure <= rp;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic idle_gap(input int n);
		in_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic drain();
		idle_gap(0);
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	function automatic logic [19:0] pick_raw();
		case ($urandom_range(0, 5))
			0: return 20'd0;
			1: return 20'hFFFFF;
			2: return 20'($urandom_range(300000, 700000));
			default: return 20'($urandom());
		endcase
	endfunction

	task automatic random_burst(input int count);
		int n;
		n = 0;
		while (n < count) begin
			int len;
			len = $urandom_range(1, 30);
			repeat (len) begin
				send_sample(pick_raw(), pick_raw());
				n++;
			end
			if ($urandom_range(0, 2) != 0)
				idle_gap($urandom_range(1, 8));
		end
	endtask

	initial begin
		sb = new();
		stall_mode = 0;
		sent = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		raw_temperature = '0;
		raw_pressure = '0;
		out_stall = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// With all calibration at zero the divisor is zero.
		send_sample(20'd0, 20'd0);
		send_sample(20'hFFFFF, 20'hFFFFF);
		drain();

		// Typical datasheet-like calibration, then extremes of the raw fields.
		load_cal({16'd50, 16'd26435, 16'd27504},
			{16'd2855, 16'hD0D0, 16'h2000, 16'd36477},
			{16'd9900, 16'hFFF9, 16'd140, 16'hFFC0}, 16'd6000);
		send_sample(20'd519888, 20'd415148);
		send_sample(20'd0, 20'd0);
		send_sample(20'hFFFFF, 20'd0);
		send_sample(20'd0, 20'hFFFFF);
		send_sample(20'hFFFFF, 20'hFFFFF);
		send_sample(20'h80000, 20'h7FFFF);
		send_sample(20'h55555, 20'hAAAAA);
		send_sample(20'hAAAAA, 20'h55555);
		drain();

		// Extreme calibration words, wrapping intermediates.
		load_cal(48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
		send_sample(20'hFFFFF, 20'd0);
		send_sample(20'd0, 20'hFFFFF);
		send_sample(20'd12345, 20'd543210);
		drain();
		load_cal(48'h8000_7FFF_FFFF, 64'h8000_7FFF_8000_FFFF,
			64'h7FFF_8000_7FFF_8000, 16'h8000);
		send_sample(20'hFFFFF, 20'hFFFFF);
		send_sample(20'd1, 20'd1);
		send_sample(20'h7FFFF, 20'h80000);
		drain();
		// P1 zero forces the divisor to zero with nonzero temperature words.
		load_cal({16'd50, 16'd26435, 16'd27504}, 64'hD0D0_2000_8E7D_0000,
			64'd0, 16'd0);
		send_sample(20'd519888, 20'd415148);
		send_sample(20'hFFFFF, 20'hFFFFF);
		drain();
		// A write to an unused index must be ignored.
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= 3'd5;
		wr_data <= 64'hFFFF_FFFF_FFFF_FFFF;
		@(negedge clk);
		wr_en <= 1'b0;
		send_sample(20'd400000, 20'd300000);
		drain();

		// Random phases, each with fresh calibration and one of four stall patterns in turn.
		for (int ph = 0; ph < 12; ph++) begin
			logic [63:0] lo;
			stall_mode = ph % 4;
			lo = {$urandom(), $urandom()};
			if (ph % 3 == 0)
				lo[15:0] = 16'($urandom_range(20000, 40000));
			if (ph == 11)
				lo[15:0] = 16'd0;
			load_cal(48'({$urandom(), $urandom()}), lo, {$urandom(), $urandom()},
				16'($urandom()));
			random_burst(125);
			drain();
		end
		stall_mode = 0;

		$display("Sent %0d words, checked %0d, %0d with a zero divisor.",
			sent, sb.checked, sb.zero_seen);
		$display("Calibration covered zero, typical, all-ones and sign-edge values.");
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	initial begin
		#400000;
		$display("Timed out waiting for the core.");
		$display("tb_top: errors");
		$finish;
	end

endmodule

### temp_pressure_compensation_core.f
src/tpc_pkg.sv
src/tpc_front.sv
src/tpc_div.sv
src/tpc_back.sv
src/temp_pressure_compensation_core.sv
dv/tb_top.sv
